// ===== rtl/core/bitmap_page_frame_allocator_top_macros.svh =====
// Assertion macros for the page frame allocator checker
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_TOP_MACROS_SVH

`define BPFA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpfa check failed");

`define BPFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpfa check failed");

`endif

// ===== rtl/core/bpfa_pkg.sv =====
package bpfa_pkg;

  localparam int CNT_W     = 13;
  localparam int WORD_BITS = 8;
  localparam int WSH       = 3;

  localparam logic [1:0] FN_ALLOC   = 2'd0;
  localparam logic [1:0] FN_FREE    = 2'd1;
  localparam logic [1:0] FN_RESERVE = 2'd2;
  localparam logic [1:0] FN_REGION  = 2'd3;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOINIT  = 2'd1,
    ST_NOSPACE = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CLS_RESP   = 2'd0,
    CLS_SEARCH = 2'd1,
    CLS_MARK   = 2'd2
  } cls_t;

  typedef struct packed {
    logic cap;
    logic clr_step;
    logic dec;
    logic go_search;
    logic go_mark;
    logic go_alloc;
    logic no_space;
  } bpfa_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic done;
    logic found;
    cls_t cls;
  } bpfa_sts_t;

endpackage

// ===== rtl/core/bpfa_ctrl.sv =====
module bpfa_ctrl import bpfa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  bpfa_sts_t sts,
  output bpfa_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CLEAR  = 6'b000010,
    S_DECODE = 6'b000100,
    S_SEARCH = 6'b001000,
    S_MARK   = 6'b010000,
    S_RESP   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_RESP);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_CLEAR: begin
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.clr_step = 1'b1;
        end
      end
      S_DECODE: begin
        cmd.dec = 1'b1;
        unique case (sts.cls)
          CLS_SEARCH: begin
            cmd.go_search = 1'b1;
            state_nxt     = S_SEARCH;
          end
          CLS_MARK: begin
            cmd.go_mark = 1'b1;
            state_nxt   = S_MARK;
          end
          default: state_nxt = S_RESP;
        endcase
      end
      S_SEARCH: begin
        if (sts.done) begin
          if (sts.found) begin
            cmd.go_alloc = 1'b1;
            state_nxt    = S_MARK;
          end else begin
            cmd.no_space = 1'b1;
            state_nxt    = S_RESP;
          end
        end
      end
      S_MARK: begin
        if (sts.done) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_we) begin
      state_nxt = S_CLEAR;
      cmd.clr_step = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/bpfa_datapath.sv =====
module bpfa_datapath import bpfa_pkg::*; #(
  parameter int MAX_PAGES  = 4096,
  parameter int PAGE_BYTES = 4096,
  parameter int ADDR_BITS  = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CNT_W-1:0]     cfg_data,
  input  logic [1:0]           in_func,
  input  logic [ADDR_BITS-1:0] in_byte_address,
  input  logic [CNT_W-1:0]     in_run_count,
  input  logic [ADDR_BITS-1:0] in_region_length,
  input  bpfa_cmd_t            cmd,
  output bpfa_sts_t            sts,
  output logic [1:0]           out_status,
  output logic [ADDR_BITS-1:0] out_alloc_address,
  output logic [CNT_W-1:0]     out_used_pages,
  output logic [CNT_W-1:0]     out_free_pages
);

  localparam int PSH   = $clog2(PAGE_BYTES);
  localparam int WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PW    = CNT_W + 1;
  localparam int WW    = PW - WSH;
  localparam int LW    = PSH + 2;

  logic [WORD_BITS-1:0] map_mem [WORDS];
  logic [WORD_BITS-1:0] rd_q;

  logic [CNT_W-1:0]     pc_r, used_r, free_r, cnt_r, run_r, start_r;
  logic [1:0]           func_r;
  logic [ADDR_BITS-1:0] addr_r, len_r, alloc_r;
  status_t              status_r;
  logic [PW-1:0]        lo_r, hi_r;
  logic                 set_r, srch_r, act_r, pv_r, found_r, done_r;
  logic [WW-1:0]        rd_w_r, pr_w_r, clr_w_r;

  logic [CNT_W-1:0]     cfg_sat;
  logic [ADDR_BITS-1:0] first;
  logic                 first_ok;
  logic [PW-1:0]        first_p, rem, clip, dec_hi;
  logic [LW-1:0]        lsum;
  logic [ADDR_BITS:0]   pages, runlen;
  cls_t                 dec_cls;
  status_t              dec_status;

  logic [PW-1:0]        base;
  logic [CNT_W-1:0]     s_run, s_start;
  logic                 s_found;
  logic [WORD_BITS-1:0] m_word;
  logic [3:0]           chg;
  logic                 last, fin;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic [WORD_BITS-1:0] mem_wd;

  assign cfg_sat = (int'(cfg_data) > MAX_PAGES) ? CNT_W'(MAX_PAGES) : cfg_data;

  assign first    = addr_r >> PSH;
  assign first_ok = first < ADDR_BITS'(pc_r);
  assign first_p  = PW'(first);
  assign rem      = PW'(pc_r) - first_p;
  assign lsum     = LW'(len_r[PSH-1:0]) + LW'(addr_r[PSH-1:0]) + LW'(PAGE_BYTES - 1);
  assign pages    = (ADDR_BITS+1)'(len_r >> PSH) + (ADDR_BITS+1)'(lsum[LW-1:PSH]);
  assign runlen   = (func_r == FN_REGION) ? pages : (ADDR_BITS+1)'(cnt_r);
  assign clip     = (runlen < (ADDR_BITS+1)'(rem)) ? PW'(runlen) : rem;
  assign dec_hi   = first_p + clip;

  always_comb begin
    dec_cls    = CLS_RESP;
    dec_status = ST_DONE;
    if (pc_r == '0) begin
      dec_status = ST_NOINIT;
    end else begin
      case (func_r) inside
        FN_ALLOC: begin
          if (cnt_r == '0) begin
            dec_status = ST_IGNORED;
          end else if (cnt_r > pc_r) begin
            dec_status = ST_NOSPACE;
          end else begin
            dec_cls = CLS_SEARCH;
          end
        end
        FN_FREE, FN_RESERVE: begin
          if (addr_r == '0 || cnt_r == '0 || !first_ok) begin
            dec_status = ST_IGNORED;
          end else begin
            dec_cls = CLS_MARK;
          end
        end
        default: begin
          if (len_r == '0 || first == '0 || !first_ok) begin
            dec_status = ST_IGNORED;
          end else begin
            dec_cls = CLS_MARK;
          end
        end
      endcase
    end
  end

  assign base = {pr_w_r, WSH'(0)};

  always_comb begin
    logic [PW-1:0] p;
    s_run   = run_r;
    s_found = found_r;
    s_start = start_r;
    for (int j = 0; j < WORD_BITS; j++) begin
      p = base + PW'(j);
      if (!s_found && p < PW'(pc_r)) begin
        s_run = rd_q[j] ? '0 : s_run + 1'b1;
        if (s_run == cnt_r) begin
          s_found = 1'b1;
          s_start = CNT_W'(p + 1'b1 - PW'(cnt_r));
        end
      end
    end
  end

  always_comb begin
    logic [PW-1:0] p;
    logic          hit;
    m_word = rd_q;
    chg    = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      p   = base + PW'(j);
      hit = (p >= lo_r) && (p < hi_r);
      if (hit) begin
        m_word[j] = set_r;
        chg = chg + 4'((rd_q[j] != set_r) ? 1 : 0);
      end
    end
  end

  assign last = (base + PW'(WORD_BITS)) >= hi_r;
  assign fin  = act_r && pv_r && (last || (srch_r && s_found));

  assign mem_we = cmd.clr_step || (act_r && pv_r && !srch_r);
  assign mem_wa = cmd.clr_step ? AW'(clr_w_r) : AW'(pr_w_r);
  assign mem_wd = cmd.clr_step ? '0 : m_word;

  always_ff @(posedge clk) begin
    rd_q <= map_mem[AW'(rd_w_r)];
    if (mem_we) begin
      map_mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= '0;
      used_r  <= '0;
      free_r  <= '0;
      act_r   <= 1'b0;
      pv_r    <= 1'b0;
      done_r  <= 1'b0;
      clr_w_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (cfg_we) begin
        pc_r    <= cfg_sat;
        used_r  <= '0;
        free_r  <= cfg_sat;
        clr_w_r <= '0;
      end
      if (cmd.clr_step) begin
        clr_w_r <= clr_w_r + 1'b1;
      end
      if (cmd.cap) begin
        func_r <= in_func;
        addr_r <= in_byte_address;
        cnt_r  <= in_run_count;
        len_r  <= in_region_length;
      end
      if (act_r) begin
        rd_w_r <= rd_w_r + 1'b1;
        pr_w_r <= rd_w_r;
        pv_r   <= 1'b1;
        if (pv_r) begin
          if (srch_r) begin
            run_r   <= s_run;
            found_r <= s_found;
            start_r <= s_start;
          end else if (set_r) begin
            used_r <= used_r + CNT_W'(chg);
            free_r <= free_r - CNT_W'(chg);
          end else begin
            used_r <= used_r - CNT_W'(chg);
            free_r <= free_r + CNT_W'(chg);
          end
        end
        if (fin) begin
          act_r  <= 1'b0;
          pv_r   <= 1'b0;
          done_r <= 1'b1;
        end
      end
      if (cmd.dec) begin
        status_r <= dec_status;
        alloc_r  <= '0;
        lo_r     <= first_p;
        hi_r     <= dec_hi;
        set_r    <= (func_r != FN_FREE);
      end
      if (cmd.go_search) begin
        srch_r  <= 1'b1;
        act_r   <= 1'b1;
        pv_r    <= 1'b0;
        rd_w_r  <= '0;
        run_r   <= '0;
        found_r <= 1'b0;
        hi_r    <= PW'(pc_r);
      end
      if (cmd.go_mark) begin
        srch_r <= 1'b0;
        act_r  <= 1'b1;
        pv_r   <= 1'b0;
        rd_w_r <= WW'(first_p >> WSH);
      end
      if (cmd.go_alloc) begin
        srch_r  <= 1'b0;
        act_r   <= 1'b1;
        pv_r    <= 1'b0;
        set_r   <= 1'b1;
        lo_r    <= PW'(start_r);
        hi_r    <= PW'(start_r) + PW'(cnt_r);
        rd_w_r  <= WW'(start_r >> WSH);
        alloc_r <= ADDR_BITS'(start_r) << PSH;
      end
      if (cmd.no_space) begin
        status_r <= ST_NOSPACE;
      end
    end
  end

  assign sts.clr_done = {clr_w_r, WSH'(0)} >= PW'(pc_r);
  assign sts.done     = done_r;
  assign sts.found    = found_r;
  assign sts.cls      = dec_cls;

  assign out_status        = status_r;
  assign out_alloc_address = alloc_r;
  assign out_used_pages    = used_r;
  assign out_free_pages    = free_r;

endmodule

// ===== rtl/core/bitmap_page_frame_allocator_top.sv =====
// Bitmap page frame allocator: one used bit per page, kept in a map memory of 8-bit
// words, with used and free page counters. One request is handled at a time. The request
// is accepted in the idle state and then decoded. A word scan through the map handles 8
// pages per cycle, with a registered memory read ahead of each word and a hand-over to
// the controller at the end. An allocate scans from page 0 until the first fitting run
// and then marks the run. When marking, an unaligned run touches one extra word. Free,
// reserve and region requests only mark. The result then shows until it is taken with
// out_stall low. Requests that are refused answer right after the decode state. The worst
// case is an allocate of the whole map. Writing the page count register starts a clearing
// pass that zeroes the map words holding the configured pages. No request is accepted
// during the clearing pass.
module bitmap_page_frame_allocator_top import bpfa_pkg::*; #(
  parameter int MAX_PAGES  = 4096,
  parameter int PAGE_BYTES = 4096,
  parameter int ADDR_BITS  = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CNT_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_func,
  input  logic [ADDR_BITS-1:0] in_byte_address,
  input  logic [CNT_W-1:0]     in_run_count,
  input  logic [ADDR_BITS-1:0] in_region_length,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output logic [ADDR_BITS-1:0] out_alloc_address,
  output logic [CNT_W-1:0]     out_used_pages,
  output logic [CNT_W-1:0]     out_free_pages
);

  bpfa_cmd_t cmd;
  bpfa_sts_t sts;

  bpfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bpfa_datapath #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES),
    .ADDR_BITS  (ADDR_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .in_func           (in_func),
    .in_byte_address   (in_byte_address),
    .in_run_count      (in_run_count),
    .in_region_length  (in_region_length),
    .cmd               (cmd),
    .sts               (sts),
    .out_status        (out_status),
    .out_alloc_address (out_alloc_address),
    .out_used_pages    (out_used_pages),
    .out_free_pages    (out_free_pages)
  );

endmodule

// ===== rtl/core/bpfa_checker.sv =====
`include "bitmap_page_frame_allocator_top_macros.svh"

module bpfa_checker import bpfa_pkg::*; #(
  parameter int ADDR_BITS = 48
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [1:0]           out_status,
  input logic [ADDR_BITS-1:0] out_alloc_address,
  input logic [CNT_W-1:0]     out_used_pages,
  input logic [CNT_W-1:0]     out_free_pages
);

  `BPFA_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_alloc_address) && $stable(out_used_pages) && $stable(out_free_pages))
  `BPFA_ASSERT_SAME(a_addr_zero, clk, rst_n, out_valid && out_status != ST_DONE, out_alloc_address == '0)
  `BPFA_ASSERT_NEXT(a_one_result, clk, rst_n, out_valid && !out_stall, !out_valid)
  `BPFA_ASSERT_SAME(a_busy_stall, clk, rst_n, out_valid, in_stall)

endmodule

bind bitmap_page_frame_allocator_top bpfa_checker #(.ADDR_BITS(ADDR_BITS)) u_bpfa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_alloc_address (out_alloc_address),
  .out_used_pages    (out_used_pages),
  .out_free_pages    (out_free_pages)
);
